// ===== rtl/core/lpnsc_pkg.sv =====
package lpnsc_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [2:0] LENGTH_SIZE_RESET = 3'd4;

	localparam logic [1:0] KIND_START   = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_TRUNC   = 2'd2;

	// Commands passed from the framing front end to the output back end.
	typedef enum logic [2:0] {
		OP_START4,
		OP_START3,
		OP_PAY,
		OP_PAY_TRUNC,
		OP_TRUNC
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

endpackage

// ===== rtl/core/lpnsc_front.sv =====
module lpnsc_front
	import lpnsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       sample_first,
	input  logic       sample_last,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	logic [2:0]  length_size_q;
	logic        in_payload_q;
	logic [2:0]  prefix_count_q;
	logic [31:0] length_accum_q;
	logic [31:0] payload_left_q;
	logic        first_unit_q;

	logic        ip, fu, nip, nfu, has_cmd, accept;
	logic [2:0]  pc, npc, pc_inc, eff_size;
	logic [31:0] acc, nacc, pl, npl, new_acc;
	op_t         op;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (length_size_q == 3'd0) begin
			eff_size = 3'd1;
		end else if (length_size_q > 3'd4) begin
			eff_size = 3'd4;
		end else begin
			eff_size = length_size_q;
		end
	end

	always_comb begin
		// A new sample restarts framing before its first byte is handled.
		ip  = sample_first ? 1'b0  : in_payload_q;
		pc  = sample_first ? 3'd0  : prefix_count_q;
		acc = sample_first ? 32'd0 : length_accum_q;
		pl  = sample_first ? 32'd0 : payload_left_q;
		fu  = sample_first ? 1'b1  : first_unit_q;

		new_acc = {acc[23:0], in_byte};
		pc_inc  = pc + 3'd1;

		nip     = ip;
		npc     = pc;
		nacc    = acc;
		npl     = pl;
		nfu     = fu;
		has_cmd = 1'b0;
		op      = OP_PAY;

		if (!ip) begin
			if (pc_inc >= eff_size) begin
				// A unit with a nonzero length that ends the sample has no bytes and gets no start code.
				if (!(sample_last && new_acc != 32'd0)) begin
					has_cmd = 1'b1;
					op      = fu ? OP_START4 : OP_START3;
				end
				nfu  = 1'b0;
				npc  = 3'd0;
				nacc = 32'd0;
				if (new_acc != 32'd0) begin
					nip = 1'b1;
					npl = new_acc;
				end
			end else begin
				npc  = pc_inc;
				nacc = new_acc;
			end
		end else begin
			has_cmd = 1'b1;
			op      = OP_PAY;
			npl     = pl - 32'd1;
			if (npl == 32'd0) begin
				nip = 1'b0;
			end
		end

		if (sample_last) begin
			if (nip || npc != 3'd0) begin
				op      = has_cmd ? OP_PAY_TRUNC : OP_TRUNC;
				has_cmd = 1'b1;
			end
			nip  = 1'b0;
			npc  = 3'd0;
			nacc = 32'd0;
			npl  = 32'd0;
			nfu  = 1'b1;
		end
	end

	assign push          = accept && has_cmd;
	assign push_cmd.op   = op;
	assign push_cmd.data = in_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_size_q  <= LENGTH_SIZE_RESET;
			in_payload_q   <= 1'b0;
			prefix_count_q <= 3'd0;
			length_accum_q <= 32'd0;
			payload_left_q <= 32'd0;
			first_unit_q   <= 1'b1;
		end else begin
			if (cfg_we) begin
				length_size_q <= cfg_wdata;
			end
			if (accept) begin
				in_payload_q   <= nip;
				prefix_count_q <= npc;
				length_accum_q <= nacc;
				payload_left_q <= npl;
				first_unit_q   <= nfu;
			end
		end
	end

endmodule

// ===== rtl/core/lpnsc_queue.sv =====
module lpnsc_queue
	import lpnsc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/lpnsc_back.sv =====
module lpnsc_back
	import lpnsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       head_cmd,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] out_kind,
	output logic       out_last
);

	logic [1:0] beat_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [1:0] out_kind_q;
	logic       out_last_q;

	logic       load, final_beat;
	logic [7:0] b_byte;
	logic [1:0] b_kind;

	assign load = !out_valid_q || out_ready;
	assign pop  = load && !q_empty && final_beat;

	// Expand the head request into the byte of the current beat.
	always_comb begin
		b_byte     = 8'd0;
		b_kind     = KIND_START;
		final_beat = 1'b1;
		unique case (head_cmd.op)
			OP_START4: begin
				b_byte     = (beat_q == 2'd3) ? 8'd1 : 8'd0;
				final_beat = (beat_q == 2'd3);
			end
			OP_START3: begin
				b_byte     = (beat_q == 2'd2) ? 8'd1 : 8'd0;
				final_beat = (beat_q == 2'd2);
			end
			OP_PAY: begin
				b_byte = head_cmd.data;
				b_kind = KIND_PAYLOAD;
			end
			OP_PAY_TRUNC: begin
				final_beat = (beat_q == 2'd1);
				if (beat_q == 2'd0) begin
					b_byte = head_cmd.data;
					b_kind = KIND_PAYLOAD;
				end else begin
					b_kind = KIND_TRUNC;
				end
			end
			OP_TRUNC: begin
				b_kind = KIND_TRUNC;
			end
			default: begin
				b_kind = KIND_TRUNC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) begin
				beat_q <= final_beat ? 2'd0 : beat_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			out_byte_q <= b_byte;
			out_kind_q <= b_kind;
			out_last_q <= final_beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_kind  = out_kind_q;
	assign out_last  = out_last_q;

endmodule

// ===== rtl/core/length_prefixed_nal_to_start_codes.sv =====
// An accepted byte that makes a request goes into the queue and then into the
// output register. Throughput: one input byte per cycle while the queue is not
// full; the output register emits one byte per cycle while out_ready allows,
// so a start code is four or three bytes and a truncated payload byte two,
// with QUEUE_DEPTH requests buffered between. Reset: arst_n clears framing
// state and the queue at once; length_size returns to 4.
module length_prefixed_nal_to_start_codes
	import lpnsc_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       sample_first,
	input  logic       sample_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] out_kind,
	output logic       out_last
);

	logic q_full, q_empty, push, pop;
	cmd_t push_cmd, head_cmd;

	lpnsc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.sample_first (sample_first),
		.sample_last  (sample_last),
		.q_full       (q_full),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	lpnsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head_cmd (head_cmd)
	);

	lpnsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head_cmd  (head_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_kind  (out_kind),
		.out_last  (out_last)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import lpnsc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_REQUESTS = 65;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} req_t;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       last;
	} out_rec_t;

	// Tracks the framing of the byte stream and holds the Annex B bytes still owed.
	class annexb_scoreboard;
		logic [2:0]  length_size;
		bit          in_payload;
		logic [2:0]  prefix_count;
		logic [31:0] length_accum;
		logic [31:0] payload_left;
		bit          first_unit;
		out_rec_t    expected_q[$];
		int          errors;
		int          requests;
		int          results;
		int          start_bytes;
		int          truncations;

		function new();
			length_size = LENGTH_SIZE_RESET;
			restart();
		endfunction

		function void restart();
			in_payload = 1'b0;
			prefix_count = '0;
			length_accum = '0;
			payload_left = '0;
			first_unit = 1'b1;
		endfunction

		function void absorb_byte(logic [7:0] b, logic first, logic last);
			out_rec_t    emitted[$];
			logic [31:0] unit_len;
			int unsigned eff;
			eff = (length_size == 3'd0) ? 1 : (length_size > 3'd4) ? 4 : length_size;
			requests++;
			if (first)
				restart();
			if (!in_payload) begin
				length_accum = {length_accum[23:0], b};
				prefix_count = prefix_count + 3'd1;
				if (prefix_count >= eff) begin
					unit_len = length_accum;
					prefix_count = '0;
					length_accum = '0;
					// A unit with a nonzero length that ends the sample has no bytes, so it gets no start code.
					if (!(last && unit_len != 0)) begin
						repeat (first_unit ? 3 : 2)
							emitted.push_back(out_rec_t'{8'h00, KIND_START, 1'b0});
						emitted.push_back(out_rec_t'{8'h01, KIND_START, 1'b0});
					end
					first_unit = 1'b0;
					if (unit_len != 0) begin
						in_payload = 1'b1;
						payload_left = unit_len;
					end
				end
			end else begin
				emitted.push_back(out_rec_t'{b, KIND_PAYLOAD, 1'b0});
				payload_left = payload_left - 32'd1;
				if (payload_left == 0)
					in_payload = 1'b0;
			end
			if (last) begin
				if (in_payload || prefix_count != 0)
					emitted.push_back(out_rec_t'{8'h00, KIND_TRUNC, 1'b0});
				restart();
			end
			if (emitted.size() > 0)
				emitted[emitted.size()-1].last = 1'b1;
			foreach (emitted[i])
				expected_q.push_back(emitted[i]);
		endfunction

		function void check_out_byte(logic [7:0] data, logic [1:0] kind, logic last);
			out_rec_t exp_rec;
			results++;
			if (expected_q.size() == 0) begin
				$error("unexpected result: out_byte %h out_kind %0d out_last %0d",
					data, kind, last);
				errors++;
				return;
			end
			exp_rec = expected_q.pop_front();
			if (kind == KIND_START)
				start_bytes++;
			if (kind == KIND_TRUNC)
				truncations++;
			if (exp_rec.data !== data) begin
				$error("out_byte: expected %h, got %h", exp_rec.data, data);
				errors++;
			end
			if (exp_rec.kind !== kind) begin
				$error("out_kind: expected %0d, got %0d", exp_rec.kind, kind);
				errors++;
			end
			if (exp_rec.last !== last) begin
				$error("out_last: expected %0d, got %0d", exp_rec.last, last);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       sample_first;
	logic       sample_last;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic [1:0] out_kind;
	logic       out_last;

	annexb_scoreboard sb;
	int in_idle_pct = 26;
	int out_idle_pct = 26;
	int hold_request = 0;
	int cycle_count = 0;

	length_prefixed_nal_to_start_codes dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.sample_first(sample_first),
		.sample_last(sample_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.out_kind(out_kind),
		.out_last(out_last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top failed");
		$finish;
	end

	// Output side: checks every accepted result and decides out_ready for the next edge.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_out_byte(out_byte, out_kind, out_last);
			if (hold_request != 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= out_idle_pct);
			end
		end
	end

	task automatic send_req(input req_t r);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= r.data;
		sample_first <= r.first;
		sample_last <= r.last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.absorb_byte(r.data, r.first, r.last);
	endtask

	task automatic send_run(input req_t seq[$]);
		foreach (seq[i])
			send_req(seq[i]);
	endtask

	// Mostly well-formed samples with random lengths and payload; some are cut short,
	// some never close, and a few are plain noise.
	task automatic send_sample(input int unsigned eff);
		req_t        seq[$];
		int unsigned len;
		int unsigned mode;
		int unsigned pick;
		mode = $urandom_range(99);
		if (mode >= 92) begin
			repeat ($urandom_range(1, 8))
				seq.push_back(req_t'{8'($urandom_range(255)), ($urandom_range(9) == 0),
					($urandom_range(4) == 0)});
		end else begin
			repeat ($urandom_range(1, 3)) begin
				pick = $urandom_range(99);
				if (pick < 15)
					len = 0;
				else if (pick < 85)
					len = $urandom_range(1, 6);
				else
					len = $urandom_range(7, 24);
				for (int k = int'(eff) - 1; k >= 0; k--)
					seq.push_back(req_t'{8'(len >> (8 * k)), 1'b0, 1'b0});
				repeat (len)
					seq.push_back(req_t'{8'($urandom_range(255)), 1'b0, 1'b0});
			end
			if (mode >= 72 && mode < 86) begin
				pick = $urandom_range(1, seq.size());
				while (seq.size() > pick)
					void'(seq.pop_back());
			end
			seq[0].first = 1'b1;
			if (mode < 86)
				seq[seq.size()-1].last = 1'b1;
		end
		send_run(seq);
	endtask

	task automatic drain_outputs();
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_length_size(input logic [2:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.length_size = value;
	endtask

	initial begin
		req_t        directed_q[$];
		logic [2:0]  phase_sizes[8];
		int unsigned eff;
		int          target;
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		in_byte <= '0;
		sample_first <= 1'b0;
		sample_last <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset length size of four: a plain unit, a zero length followed by a cut payload,
		// a sample ending on its last length byte, one ending inside the length, and a
		// restart in the middle of a length that then ends on a zero length.
		directed_q = '{
			'{8'h00, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
			'{8'h01, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b1},
			'{8'h00, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
			'{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
			'{8'h00, 1'b0, 1'b0}, '{8'h03, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
			'{8'h7F, 1'b0, 1'b1},
			'{8'h00, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
			'{8'h05, 1'b0, 1'b1},
			'{8'h80, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b1},
			'{8'h12, 1'b1, 1'b0}, '{8'h00, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b0},
			'{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b1}
		};
		send_run(directed_q);
		in_valid <= 1'b0;
		drain_outputs();

		phase_sizes = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd7, 3'd5, 3'd6, 3'd4};
		foreach (phase_sizes[p]) begin
			write_length_size(phase_sizes[p]);
			eff = (phase_sizes[p] == 3'd0) ? 1 : (phase_sizes[p] > 3'd4) ? 4 : phase_sizes[p];
			in_idle_pct = (p == 3) ? 0 : 26;
			out_idle_pct = (p == 3) ? 0 : 26;
			// Starve the output for a while so the queue fills and the input backs up.
			if (p == 1 || p == 5)
				hold_request = 150;
			target = sb.requests + PHASE_REQUESTS;
			while (sb.requests < target)
				send_sample(eff);
			in_valid <= 1'b0;
			drain_outputs();
		end

		repeat (12) @(posedge clk);
		$display("Sent %0d request bytes across all eight length size settings,",
			sb.requests);
		$display("checked %0d output bytes: %0d start code bytes, %0d truncation markers.",
			sb.results, sb.start_bytes, sb.truncations);
		if (sb.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
